// ===== rtl/core/uid_alloc_pkg.sv =====
package uid_alloc_pkg;

  localparam int ID_W = 64;
  localparam int OP_W = 2;
  localparam int ST_W = 2;

  localparam logic [ID_W-1:0] ID_ALL_ONES = '1;

  typedef logic [OP_W-1:0] opcode_t;
  typedef logic [ST_W-1:0] status_t;
  typedef logic [ID_W-1:0] id_t;

  localparam opcode_t OP_ALLOC_AUTO = 2'd0;
  localparam opcode_t OP_ALLOC_REQ  = 2'd1;
  localparam opcode_t OP_RELEASE    = 2'd2;
  localparam opcode_t OP_UNUSED     = 2'd3;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_REJECT    = 2'd1;
  localparam status_t ST_FULL      = 2'd2;
  localparam status_t ST_NOT_FOUND = 2'd3;

  // one table entry: occupancy flag plus identifier
  typedef struct packed {
    logic vld;
    id_t  id;
  } entry_t;

endpackage

// ===== rtl/core/unique_id_allocator_top.sv =====
// Walks per item: release and requested allocation make one table walk; a zero value
//   or the unused opcode skips the walk. Automatic allocation makes one walk when
//   last+1 is free or the table is full, and up to TABLE_DEPTH + 1 walks when the
//   lowest-free search runs.
// Throughput: one item at a time; the single-port table walk (one entry per cycle) sets it.
// Reset: synchronous, active high; a clearing pass over every table entry precedes the first input.
module unique_id_allocator_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [uid_alloc_pkg::OP_W-1:0]   opcode,
  input  logic [uid_alloc_pkg::ID_W-1:0]   id_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [uid_alloc_pkg::ID_W-1:0]   result_id,
  output logic [uid_alloc_pkg::ST_W-1:0]   status
);
  import uid_alloc_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
  // the lowest-free search never needs to look past TABLE_DEPTH + 1
  localparam id_t SEARCH_LIMIT = ID_W'(TABLE_DEPTH + 1);

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,  // post-reset sweep clearing occupancy
    S_IDLE  = 5'b00010,  // waiting for an input transfer
    S_SCAN  = 5'b00100,  // walking the table against the candidate
    S_EVAL  = 5'b01000,  // act on walk results, write table
    S_FIN   = 5'b10000   // hand result to output register
  } state_t;

  state_t state;

  // table memory, single write port, registered read
  entry_t               id_store [TABLE_DEPTH];
  entry_t               rdata;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  entry_t               mem_wdata;

  // current operation
  opcode_t              op;
  id_t                  val;
  id_t                  cand;       // value the walk compares against
  logic                 searching;  // auto alloc is in lowest-free search
  id_t                  last_issued;

  // walk bookkeeping
  logic [CNT_W-1:0]     scan_addr;
  logic                 pend;       // rdata holds entry pend_idx
  logic [IDX_W-1:0]     pend_idx;
  logic                 match_found;
  logic [IDX_W-1:0]     match_idx;
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;
  logic [IDX_W-1:0]     clr_cnt;

  // pending result
  id_t                  res_id;
  status_t              res_st;

  logic                 rd_en;
  logic                 hit;
  logic                 out_load;

  assign in_ready = (state == S_IDLE);
  assign rd_en    = (state == S_SCAN) && (scan_addr < DEPTH_CNT);
  // the shared 64-bit comparator
  assign hit      = rdata.vld && (rdata.id == cand);
  assign out_load = (state == S_FIN) && (!out_valid || out_ready);

  // memory write select: clearing sweep, insert at free slot, or release
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt;
    mem_wdata = '{vld: 1'b0, id: '0};
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == S_EVAL) begin
      unique case (op)
        OP_ALLOC_AUTO: begin
          mem_we    = free_found && !match_found;
          mem_waddr = free_idx;
          mem_wdata = '{vld: 1'b1, id: cand};
        end
        OP_ALLOC_REQ: begin
          mem_we    = free_found && !match_found;
          mem_waddr = free_idx;
          mem_wdata = '{vld: 1'b1, id: cand};
        end
        OP_RELEASE: begin
          mem_we    = match_found;
          mem_waddr = match_idx;
          mem_wdata = '{vld: 1'b0, id: cand};
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      id_store[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata <= id_store[scan_addr[IDX_W-1:0]];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_cnt     <= '0;
      last_issued <= '0;
      pend        <= 1'b0;
      searching   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        result_id <= res_id;
        status    <= res_st;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == LAST_IDX) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          scan_addr   <= '0;
          pend        <= 1'b0;
          match_found <= 1'b0;
          free_found  <= 1'b0;
          if (in_valid) begin
            op        <= opcode;
            val       <= id_value;
            res_id    <= '0;
            unique case (opcode)
              OP_ALLOC_AUTO: begin
                // fast path tries last+1 unless it would pass all-ones
                if (last_issued == ID_ALL_ONES) begin
                  cand      <= ID_W'(1);
                  searching <= 1'b1;
                end else begin
                  cand      <= last_issued + 1'b1;
                  searching <= 1'b0;
                end
                state <= S_SCAN;
              end
              OP_ALLOC_REQ: begin
                cand <= id_value;
                if (id_value == '0) begin
                  res_st <= ST_REJECT;
                  state  <= S_FIN;
                end else begin
                  state <= S_SCAN;
                end
              end
              OP_RELEASE: begin
                cand <= id_value;
                if (id_value == '0) begin
                  res_st <= ST_NOT_FOUND;
                  state  <= S_FIN;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                res_st <= ST_REJECT;
                state  <= S_FIN;
              end
            endcase
          end
        end

        S_SCAN: begin
          if (rd_en) begin
            scan_addr <= scan_addr + 1'b1;
          end
          pend     <= rd_en;
          pend_idx <= scan_addr[IDX_W-1:0];
          if (pend) begin
            if (hit && !match_found) begin
              match_found <= 1'b1;
              match_idx   <= pend_idx;
            end
            if (!rdata.vld && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= pend_idx;
            end
            if (pend_idx == LAST_IDX) begin
              state <= S_EVAL;
            end
          end
        end

        S_EVAL: begin
          unique case (op)
            OP_ALLOC_AUTO: begin
              priority if (!free_found) begin
                res_st <= ST_FULL;
                state  <= S_FIN;
              end else if (!match_found) begin
                last_issued <= cand;
                res_id      <= cand;
                res_st      <= ST_OK;
                state       <= S_FIN;
              end else if (!searching || cand != SEARCH_LIMIT) begin
                // candidate in use: restart walk with next candidate
                searching   <= 1'b1;
                cand        <= searching ? cand + 1'b1 : ID_W'(1);
                scan_addr   <= '0;
                pend        <= 1'b0;
                match_found <= 1'b0;
                free_found  <= 1'b0;
                state       <= S_SCAN;
              end else begin
                res_st <= ST_REJECT;  // search exhausted
                state  <= S_FIN;
              end
            end
            OP_ALLOC_REQ: begin
              state <= S_FIN;
              priority if (match_found) begin
                res_st <= ST_REJECT;
              end else if (!free_found) begin
                res_st <= ST_FULL;
              end else begin
                res_id <= val;
                res_st <= ST_OK;
              end
            end
            OP_RELEASE: begin
              state <= S_FIN;
              if (match_found) begin
                res_id <= val;
                res_st <= ST_OK;
              end else begin
                res_st <= ST_NOT_FOUND;
              end
            end
            default: begin
              state  <= S_FIN;
              res_st <= ST_REJECT;
            end
          endcase
        end

        S_FIN: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== test/unique_id_allocator_checker.sv =====
module unique_id_allocator_checker #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  uid_alloc_pkg::opcode_t   opcode,
  input  uid_alloc_pkg::id_t       id_value,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  uid_alloc_pkg::id_t       result_id,
  input  uid_alloc_pkg::status_t   status,
  output int                       errors,
  output int                       pending,
  output int                       n_checked,
  output int                       n_full,
  output int                       n_rejected,
  output int                       n_not_found,
  output int                       n_scans
);
  import uid_alloc_pkg::*;

  localparam int PRINT_CAP = 100;

  typedef struct packed {
    id_t     id;
    status_t st;
  } outcome_t;

  // shadow of the identifier table
  id_t      ids [TABLE_DEPTH];
  bit       live [TABLE_DEPTH];
  id_t      last_id;
  outcome_t pending_outcomes[$];
  outcome_t predicted;
  outcome_t oldest;

  task automatic report_mismatch(string what, id_t got, id_t want);
    errors++;
    if (errors <= PRINT_CAP)
      $display("mismatch: %s got %h want %h", what, got, want);
  endtask

  // ids[] is only read where live[] is set
  function automatic int slot_of(id_t v);
    int hit;
    hit = -1;
    for (int k = TABLE_DEPTH - 1; k >= 0; k--)
      if (live[k] && ids[k] == v) hit = k;
    return hit;
  endfunction

  function automatic bit is_open_value(id_t v);
    return v != '0 && slot_of(v) < 0;
  endfunction

  function automatic int first_open_slot();
    int hit;
    hit = -1;
    for (int k = TABLE_DEPTH - 1; k >= 0; k--)
      if (!live[k]) hit = k;
    return hit;
  endfunction

  task automatic apply_table_op(input opcode_t op, input id_t val, output outcome_t want);
    int  slot;
    id_t cand;
    want.id = '0;
    want.st = ST_REJECT;
    case (op)
      OP_ALLOC_AUTO: begin
        slot = first_open_slot();
        if (slot < 0) begin
          want.st = ST_FULL;
        end else begin
          cand = '0;
          if (last_id != ID_ALL_ONES && is_open_value(last_id + 1'b1)) begin
            cand = last_id + 1'b1;
          end else begin
            // lowest free value from 1; one is always found while a slot is open
            n_scans++;
            for (int i = 1; i <= TABLE_DEPTH + 1 && cand == '0; i++)
              if (is_open_value(id_t'(i))) cand = id_t'(i);
          end
          if (cand != '0) begin
            last_id    = cand;
            ids[slot]  = cand;
            live[slot] = 1'b1;
            want.id    = cand;
            want.st    = ST_OK;
          end
        end
      end
      OP_ALLOC_REQ: begin
        // zero / in-use rejection wins over table full
        if (is_open_value(val)) begin
          slot = first_open_slot();
          if (slot < 0) begin
            want.st = ST_FULL;
          end else begin
            ids[slot]  = val;
            live[slot] = 1'b1;
            want.id    = val;
            want.st    = ST_OK;
          end
        end
      end
      OP_RELEASE: begin
        slot = (val != '0) ? slot_of(val) : -1;
        if (slot >= 0) begin
          live[slot] = 1'b0;
          want.id    = val;
          want.st    = ST_OK;
        end else begin
          want.st = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        live[k] = 1'b0;
        ids[k]  = '0;
      end
      last_id = '0;
      pending_outcomes.delete();
      errors      = 0;
      n_checked   = 0;
      n_full      = 0;
      n_rejected  = 0;
      n_not_found = 0;
      n_scans     = 0;
    end else begin
      if (in_valid && in_ready) begin
        apply_table_op(opcode, id_value, predicted);
        pending_outcomes.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch("result with nothing outstanding", result_id, '0);
        end else begin
          oldest = pending_outcomes.pop_front();
          n_checked++;
          case (oldest.st)
            ST_FULL:      n_full++;
            ST_REJECT:    n_rejected++;
            ST_NOT_FOUND: n_not_found++;
            default: ;
          endcase
          if (result_id !== oldest.id)
            report_mismatch("result_id", result_id, oldest.id);
          if (status !== oldest.st)
            report_mismatch("status", id_t'(status), id_t'(oldest.st));
        end
      end
    end
    pending = pending_outcomes.size();
  end

endmodule

// ===== test/unique_id_allocator_top_tb.sv =====
module unique_id_allocator_top_tb;
  import uid_alloc_pkg::*;

  localparam int TABLE_DEPTH   = 64;
  // worst auto allocation is TABLE_DEPTH + 1 table walks; the limit allows
  // several times that plus the receiver hold-off
  localparam int STALL_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 2 * (TABLE_DEPTH + 4);
  localparam int PHASE_ITEMS   = 250;
  localparam int SEGMENT       = 50;   // fill-heavy and drain-heavy stretches alternate

  logic    clk;
  logic    rst;
  logic    in_valid;
  logic    in_ready;
  opcode_t opcode;
  id_t     id_value;
  logic    out_valid;
  logic    out_ready;
  id_t     result_id;
  status_t status;

  int errors;
  int pending;
  int n_checked;
  int n_full;
  int n_rejected;
  int n_not_found;
  int n_scans;

  int  send_idle;      // percent of cycles the sender holds back
  int  recv_idle;      // percent of cycles the receiver holds back
  int  hold_reqs;      // long hold-offs asked of the receiver so far
  int  stall_cycles;

  // stimulus bookkeeping: identifiers believed live, used to aim releases and collisions
  id_t     live_pool[$];
  opcode_t sent_ops[$];

  unique_id_allocator_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .id_value (id_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_id(result_id),
    .status   (status)
  );

  unique_id_allocator_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .id_value   (id_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_id  (result_id),
    .status     (status),
    .errors     (errors),
    .pending    (pending),
    .n_checked  (n_checked),
    .n_full     (n_full),
    .n_rejected (n_rejected),
    .n_not_found(n_not_found),
    .n_scans    (n_scans)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: random back-pressure at the falling edge; on request, one long
  // hold-off so the block sits on a finished result and stalls its input.
  initial begin : receiver
    int holds_done;
    holds_done = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs > holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  // Track which identifiers came back live so releases mostly hit.
  always @(posedge clk) begin : pool_track
    opcode_t op_done;
    if (rst) begin
      sent_ops.delete();
      live_pool.delete();
    end else begin
      if (in_valid && in_ready)
        sent_ops.push_back(opcode);
      if (out_valid && out_ready && sent_ops.size() > 0) begin
        op_done = sent_ops.pop_front();
        if (status == ST_OK && (op_done == OP_ALLOC_AUTO || op_done == OP_ALLOC_REQ))
          live_pool.push_back(result_id);
      end
    end
  end

  // Watchdog: gives up after a long run of cycles with no transfer on either side.
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("watchdog: no transfer in %0d cycles", STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  // One input transfer. Valid drops only for a sender gap, never between
  // back-to-back items, and the payload holds until accepted.
  task automatic push_op(opcode_t op, id_t val);
    @(negedge clk);
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    id_value <= val;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sender pause until every outstanding result has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic id_t any_id();
    return {$urandom, $urandom};
  endfunction

  function automatic id_t low_id();
    return id_t'($urandom_range(1, TABLE_DEPTH + 8));
  endfunction

  // Random item. fill_bias favors allocation so the table reaches full;
  // otherwise releases dominate and the table drains.
  // Invalid-opcode items are reported as not counted.
  task automatic send_random_item(input bit fill_bias, output bit counted);
    int      roll;
    int      pick;
    int      k;
    opcode_t op;
    id_t     val;
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    val  = any_id();
    if (roll < (fill_bias ? 50 : 20)) begin
      op = OP_ALLOC_AUTO;                 // id_value is don't-care, keep it toggling
    end else if (roll < (fill_bias ? 85 : 35)) begin
      op = OP_ALLOC_REQ;
      if (pick < 30)
        val = low_id();                   // collides with auto-issued range
      else if (pick < 50 && live_pool.size() > 0)
        val = live_pool[$urandom_range(0, live_pool.size() - 1)];   // in use
      else if (pick < 90)
        val = any_id();
      else if (pick < 95)
        val = ID_ALL_ONES;
      else
        val = '0;
    end else if (roll < (fill_bias ? 97 : 95)) begin
      op = OP_RELEASE;
      if (pick < 75 && live_pool.size() > 0) begin
        k   = $urandom_range(0, live_pool.size() - 1);
        val = live_pool[k];
        live_pool.delete(k);
      end else if (pick < 85) begin
        val = low_id();
      end else if (pick >= 95) begin
        val = '0;
      end
    end else begin
      op = OP_UNUSED;
    end
    push_op(op, val);
    counted = (op != OP_UNUSED);
  endtask

  task automatic run_phase(int s_idle, int r_idle, bit with_hold);
    int counted;
    bit took;
    drain();
    send_idle = s_idle;
    recv_idle = r_idle;
    // receiver goes quiet while the sender keeps offering
    if (with_hold) hold_reqs++;
    counted = 0;
    while (counted < PHASE_ITEMS) begin
      send_random_item(((counted / SEGMENT) % 2) == 0, took);
      if (took) counted++;
    end
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    opcode    = OP_ALLOC_AUTO;
    id_value  = '0;
    hold_reqs = 0;
    send_idle = 30;
    recv_idle = 70;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: fast path, in-use and zero rejects, lowest-free search,
    // field extremes, not-found releases and the unused opcode.
    push_op(OP_ALLOC_AUTO, '0);                        // 1
    push_op(OP_ALLOC_AUTO, ID_ALL_ONES);               // 2
    push_op(OP_ALLOC_REQ,  '0);                        // zero rejected
    push_op(OP_ALLOC_REQ,  id_t'(2));                  // in use
    push_op(OP_ALLOC_REQ,  id_t'(4));
    push_op(OP_ALLOC_AUTO, '0);                        // 3
    push_op(OP_ALLOC_AUTO, '0);                        // 4 taken -> search gives 5
    push_op(OP_ALLOC_REQ,  ID_ALL_ONES);
    push_op(OP_ALLOC_REQ,  ~id_t'(1));
    push_op(OP_RELEASE,    ID_ALL_ONES);
    push_op(OP_RELEASE,    ID_ALL_ONES);               // already gone
    push_op(OP_RELEASE,    '0);                        // zero never found
    push_op(OP_UNUSED,     ID_ALL_ONES);
    push_op(OP_ALLOC_REQ,  64'h8000_0000_0000_0000);
    push_op(OP_ALLOC_REQ,  64'h5555_5555_5555_5555);
    push_op(OP_RELEASE,    64'hAAAA_AAAA_AAAA_AAAA);   // never allocated
    push_op(OP_ALLOC_REQ,  64'hAAAA_AAAA_AAAA_AAAA);
    push_op(OP_RELEASE,    id_t'(1));
    push_op(OP_ALLOC_AUTO, '0);                        // 6 via fast path
    push_op(OP_RELEASE,    ~id_t'(1));
    push_op(OP_UNUSED,     '0);

    run_phase(30, 70, 1'b0);
    run_phase(70, 30, 1'b0);
    run_phase(0, 0, 1'b1);

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("summary: %0d results checked, %0d table-full, %0d rejected, %0d not-found",
             n_checked, n_full, n_rejected, n_not_found);
    $display("summary: %0d lowest-free searches, idle mixes 30/70 70/30 0/0, %0d-cycle hold-off",
             n_scans, HOLD_CYCLES);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
